// File: rtl/tlbfm_pkg.sv
// Shared types and constants for the TLB fill and maintenance block.
package tlbfm_pkg;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned FRAME_W = 20;
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned COUNT_W = 7;

  typedef enum logic [1:0] {
    MODE_FILL    = 2'd0,
    MODE_REFRESH = 2'd1,
    MODE_PROTECT = 2'd2,
    MODE_FLUSH   = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t               mode;
    logic                has_space;
    logic [ADDR_W-1:0]   vaddr;
    logic [FRAME_W-1:0]  phys_frame;
    logic                writable;
    logic [SLOT_W-1:0]   slot_index;
    logic [ADDR_W-1:0]   seg_base;
    logic [ADDR_W-1:0]   seg_size;
  } request_t;

  typedef struct packed {
    logic                status;
    logic [SLOT_W-1:0]   slot_used;
    logic                evicted;
    logic [COUNT_W-1:0]  updated_count;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_REFRESH,
    ST_REFRESH_LAST,
    ST_PROT_READ,
    ST_PROT_CHECK,
    ST_FLUSH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic cnt_inc;
    logic rd_issue;
    logic cmp_en;
    logic fill_free;
    logic fill_evict;
    logic fault;
    logic prot_apply;
    logic flush;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic has_space;
    logic slot_free;
    logic cnt_zero;
    logic cnt_last;
  } stat_t;

endpackage

// File: rtl/tlbfm_ctrl.sv
// Sequencing state machine for the TLB fill and maintenance block.
module tlbfm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  tlbfm_pkg::mode_t mode,
  input  tlbfm_pkg::stat_t stat,
  output tlbfm_pkg::cmd_t  cmd,
  output logic             busy
);
  import tlbfm_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          unique case (mode)
            MODE_FILL:    state_next = ST_FILL;
            MODE_REFRESH: state_next = ST_REFRESH;
            MODE_PROTECT: state_next = ST_PROT_READ;
            MODE_FLUSH:   state_next = ST_FLUSH;
            default:      state_next = ST_IDLE;
          endcase
        end
      end
      ST_FILL: begin
        if (!stat.has_space) begin
          cmd.fault  = 1'b1;
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end else if (stat.slot_free) begin
          cmd.fill_free = 1'b1;
          cmd.finish    = 1'b1;
          state_next    = ST_IDLE;
        end else if (stat.cnt_last) begin
          cmd.fill_evict = 1'b1;
          cmd.finish     = 1'b1;
          state_next     = ST_IDLE;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      ST_REFRESH: begin
        cmd.rd_issue = 1'b1;
        cmd.cmp_en   = !stat.cnt_zero;
        if (stat.cnt_last) begin
          state_next = ST_REFRESH_LAST;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      ST_REFRESH_LAST: begin
        cmd.cmp_en = 1'b1;
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      ST_PROT_READ: begin
        cmd.rd_issue = 1'b1;
        state_next   = ST_PROT_CHECK;
      end
      ST_PROT_CHECK: begin
        cmd.prot_apply = 1'b1;
        cmd.finish     = 1'b1;
        state_next     = ST_IDLE;
      end
      ST_FLUSH: begin
        cmd.flush  = 1'b1;
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

// File: rtl/tlbfm_dpath.sv
// Entry storage, scan counter, compare logic and result registers of the TLB.
module tlbfm_dpath #(
  parameter int unsigned ENTRIES   = 64,
  parameter int unsigned PAGE_BITS = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  tlbfm_pkg::request_t request,
  input  tlbfm_pkg::cmd_t     cmd,
  output tlbfm_pkg::stat_t    stat,
  output tlbfm_pkg::result_t  result,
  output logic                done
);
  import tlbfm_pkg::*;

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned PW = ADDR_W - PAGE_BITS;
  localparam int unsigned XW = 9;

  request_t               req;
  logic [ENTRIES-1:0]     valid;
  logic [ENTRIES-1:0]     wr_bit;
  logic [IW-1:0]          victim;
  logic [IW-1:0]          cnt;
  logic [IW-1:0]          rd_idx;
  logic [PW-1:0]          rdata;
  logic [ADDR_W:0]        seg_end;
  logic [CW-1:0]          count;
  logic                   res_status;
  logic [SLOT_W-1:0]      res_slot;
  logic                   res_evicted;

  logic [PW-1:0]          page_mem  [ENTRIES];
  logic [FRAME_W-1:0]     frame_mem [ENTRIES];

  logic [PW-1:0]          page_in;
  logic [XW-1:0]          slot_ext;
  logic [IW-1:0]          pidx;
  logic                   slot_ok;
  logic [IW-1:0]          raddr;
  logic [IW-1:0]          wa;
  logic                   fill_we;
  logic                   match;
  logic                   hit_we;
  logic [ADDR_W:0]        prot_addr;
  logic                   prot_ok;
  logic [XW-1:0]          wa_ext;
  logic [XW-1:0]          count_ext;

  assign page_in   = req.vaddr[ADDR_W-1:PAGE_BITS];
  assign slot_ext  = XW'(req.slot_index);
  assign pidx      = slot_ext[IW-1:0];
  assign slot_ok   = (slot_ext < XW'(ENTRIES));
  assign raddr     = (req.mode == MODE_PROTECT) ? pidx : cnt;
  assign wa        = cmd.fill_evict ? victim : cnt;
  assign fill_we   = cmd.fill_free || cmd.fill_evict;
  assign match     = valid[rd_idx] && (rdata == page_in);
  assign hit_we    = cmd.cmp_en && match;
  assign prot_addr = {1'b0, rdata, {PAGE_BITS{1'b0}}};
  assign prot_ok   = slot_ok && valid[pidx] &&
                     (prot_addr >= {1'b0, req.seg_base}) && (prot_addr < seg_end);
  assign wa_ext    = XW'(wa);
  assign count_ext = XW'(count);

  always_comb begin
    stat.has_space = req.has_space;
    stat.slot_free = !valid[cnt];
    stat.cnt_zero  = (cnt == '0);
    stat.cnt_last  = (cnt == IW'(ENTRIES - 1));
  end

  // Control state: valid and writable bits, victim pointer, scan counter, strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      wr_bit <= '0;
      victim <= '0;
      cnt    <= '0;
      done   <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.load) begin
        cnt <= '0;
      end else if (cmd.cnt_inc) begin
        cnt <= cnt + IW'(1);
      end
      if (cmd.flush) begin
        valid  <= '0;
        wr_bit <= '0;
        victim <= '0;
      end
      if (fill_we) begin
        valid[wa]  <= 1'b1;
        wr_bit[wa] <= req.writable;
      end
      if (cmd.fill_evict) begin
        victim <= (victim == IW'(ENTRIES - 1)) ? '0 : victim + IW'(1);
      end
      if (hit_we) begin
        wr_bit[rd_idx] <= req.writable;
      end
      if (cmd.prot_apply && prot_ok) begin
        wr_bit[pidx] <= 1'b0;
      end
    end
  end

  // Request capture, read pipeline and result registers.
  always_ff @(posedge clk) begin
    seg_end <= {1'b0, req.seg_base} + {1'b0, req.seg_size};
    if (cmd.load) begin
      req         <= request;
      count       <= '0;
      res_status  <= 1'b0;
      res_slot    <= '0;
      res_evicted <= 1'b0;
    end else begin
      if (cmd.fault || (cmd.prot_apply && !prot_ok)) begin
        res_status <= 1'b1;
      end
      if (fill_we) begin
        res_slot <= wa_ext[SLOT_W-1:0];
      end
      if (cmd.fill_evict) begin
        res_evicted <= 1'b1;
      end
      if (hit_we) begin
        count <= count + CW'(1);
      end
    end
    if (cmd.rd_issue) begin
      rd_idx <= raddr;
    end
  end

  // Page memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (fill_we) begin
      page_mem[wa] <= page_in;
    end
    if (cmd.rd_issue) begin
      rdata <= page_mem[raddr];
    end
  end

  // Frame memory: written by fills and by refresh hits.
  always_ff @(posedge clk) begin
    if (fill_we) begin
      frame_mem[wa] <= req.phys_frame;
    end else if (hit_we) begin
      frame_mem[rd_idx] <= req.phys_frame;
    end
  end

  always_comb begin
    result.status        = res_status;
    result.slot_used     = res_slot;
    result.evicted       = res_evicted;
    result.updated_count = count_ext[COUNT_W-1:0];
  end

endmodule

// File: rtl/tlb_fill_and_maintain.sv
// Top level of the fully associative TLB with fill, refresh, protect and flush.
//
//   channel   handshake        payload    direction
//   request   start / busy     request    in: accepted when start is high and busy low
//   result    done (strobe)    result     out: valid for the single cycle done is high
//
// A fill takes the first free entry that its scan finds, evicts at the victim
// pointer when none is free and faults when there is no address space; a
// refresh compares every entry, a protect reads one entry and checks it, and a
// flush clears every valid bit. Fills and refreshes use the scan counter, which
// visits one entry per cycle over the valid bits and the single read port of
// the page memory. The block takes a new request in the cycle its result is
// shown. Reset clears every valid and writable bit and the victim pointer at
// once; page and frame memories hold no reset value. The receiver cannot stall.
module tlb_fill_and_maintain #(
  parameter int unsigned ENTRIES   = 64,
  parameter int unsigned PAGE_BITS = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  tlbfm_pkg::request_t request,
  output logic                done,
  output tlbfm_pkg::result_t  result
);
  import tlbfm_pkg::*;

  // The controller walks each request through its states; the datapath
  // holds the entries and turns each command into the matching update.
  cmd_t  cmd;
  stat_t stat;

  tlbfm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mode  (request.mode),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  tlbfm_dpath #(
    .ENTRIES   (ENTRIES),
    .PAGE_BITS (PAGE_BITS)
  ) u_dpath (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .stat    (stat),
    .result  (result),
    .done    (done)
  );

endmodule
